// ===== src/multipart_path_length_defines.svh =====
// Assertion macros for the polyline length RTL
`ifndef MULTIPART_PATH_LENGTH_DEFINES_SVH
`define MULTIPART_PATH_LENGTH_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MPL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpl assertion failed");

// Next-cycle implication, disabled during reset
`define MPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpl assertion failed");

`endif

// ===== src/mpl_pkg.sv =====
// Shared constants, types and controller encodings for the polyline length block
package mpl_pkg;

   localparam int COORD_WIDTH    = 20;
   localparam int SUM_WIDTH      = 48;
   localparam int ABS_WIDTH      = COORD_WIDTH;
   localparam int SQ_WIDTH       = 2 * ABS_WIDTH;
   localparam int SQSUM_WIDTH    = SQ_WIDTH + 1;
   localparam int ROOT_WIDTH     = ABS_WIDTH + 1;
   localparam int RAD_WIDTH      = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH      = ROOT_WIDTH + 2;
   localparam int STEP_CNT_WIDTH = $clog2(ROOT_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUMSQ,
      ST_ROOT,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic square;
      logic init_root;
      logic root_step;
      logic accumulate;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic segment;
      logic last;
      logic root_done;
      logic out_free;
   } status_type;

endpackage

// ===== src/mpl_req_if.sv =====
// Vertex channel: valid/ready handshake with point payload
interface mpl_req_if
   import mpl_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          part_start;
   logic                          last_point;

   modport source (output valid, output point_x, output point_y, output part_start,
                   output last_point, input ready);
   modport sink   (input valid, input point_x, input point_y, input part_start,
                   input last_point, output ready);
endinterface

// ===== src/mpl_rsp_if.sv =====
// Result channel: valid/ready handshake with total length payload
interface mpl_rsp_if
   import mpl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [SUM_WIDTH-1:0] total_length;
   logic                 length_saturated;

   modport source (output valid, output total_length, output length_saturated,
                   input ready);
   modport sink   (input valid, input total_length, input length_saturated,
                   output ready);
endinterface

// ===== src/mpl_ctrl.sv =====
// Controller state machine sequencing square, root iteration, accumulate and emit
module mpl_ctrl
   import mpl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.segment) begin
               state_in = ST_SUMSQ;
            end else if (status.last) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUMSQ: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            state_in = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd            = '0;
      cmd.load_item  = (state_ff == ST_IDLE) && req_valid;
      cmd.square     = (state_ff == ST_SQUARE);
      cmd.init_root  = (state_ff == ST_SUMSQ);
      cmd.root_step  = (state_ff == ST_ROOT);
      cmd.accumulate = (state_ff == ST_ACCUM);
      cmd.emit       = (state_ff == ST_EMIT) && status.out_free;
   end

endmodule

// ===== src/mpl_datapath.sv =====
// Datapath: vertex deltas, squares, bit-pair square root, saturating sum, result register
`include "multipart_path_length_defines.svh"

module mpl_datapath
   import mpl_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic                          part_start,
   input  logic                          last_point,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [SUM_WIDTH-1:0]          total_length,
   output logic                          length_saturated
);

   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
   localparam logic [STEP_CNT_WIDTH-1:0] LAST_STEP = STEP_CNT_WIDTH'(ROOT_WIDTH - 1);

   logic [COORD_WIDTH-1:0]    prev_x_ff, prev_y_ff;
   logic                      have_prev_ff, have_prev_in;
   logic                      segment_ff, last_ff;
   logic [ABS_WIDTH-1:0]      abs_x_ff, abs_y_ff;
   logic [SQ_WIDTH-1:0]       sq_x_ff, sq_y_ff;
   logic [RAD_WIDTH-1:0]      rad_ff, rad_in;
   logic [REM_WIDTH-1:0]      rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0]     root_ff, root_in;
   logic [STEP_CNT_WIDTH-1:0] step_cnt_ff, step_cnt_in;
   logic [SUM_WIDTH-1:0]      sum_ff, sum_in;
   logic                      clamp_ff, clamp_in;
   logic [SUM_WIDTH-1:0]      out_total_ff;
   logic                      out_sat_ff;
   logic                      out_valid_ff, out_valid_in;

   logic signed [COORD_WIDTH:0] diff_x, diff_y, neg_x, neg_y;
   logic [ABS_WIDTH-1:0]        abs_x_in, abs_y_in;
   logic [SQ_WIDTH-1:0]         sq_x_in, sq_y_in;
   logic [SQSUM_WIDTH-1:0]      sqsum;
   logic [REM_WIDTH-1:0]        rem_shift, trial;
   logic [SUM_WIDTH:0]          sum_ext;
   logic                        out_free;

   assign diff_x   = $signed({point_x[COORD_WIDTH-1], point_x})
                   - $signed({prev_x_ff[COORD_WIDTH-1], prev_x_ff});
   assign diff_y   = $signed({point_y[COORD_WIDTH-1], point_y})
                   - $signed({prev_y_ff[COORD_WIDTH-1], prev_y_ff});
   assign neg_x    = -diff_x;
   assign neg_y    = -diff_y;
   assign abs_x_in = diff_x[COORD_WIDTH] ? neg_x[ABS_WIDTH-1:0] : diff_x[ABS_WIDTH-1:0];
   assign abs_y_in = diff_y[COORD_WIDTH] ? neg_y[ABS_WIDTH-1:0] : diff_y[ABS_WIDTH-1:0];

   assign sq_x_in = abs_x_ff * abs_x_ff;
   assign sq_y_in = abs_y_ff * abs_y_ff;
   assign sqsum   = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   assign rem_shift = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign sum_ext   = {1'b0, sum_ff} + {{(SUM_WIDTH + 1 - ROOT_WIDTH){1'b0}}, root_ff};
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      step_cnt_in = step_cnt_ff;
      if (cmd.init_root) begin
         rad_in      = RAD_WIDTH'(sqsum);
         rem_in      = '0;
         root_in     = '0;
         step_cnt_in = '0;
      end else if (cmd.root_step) begin
         rad_in      = rad_ff << 2;
         step_cnt_in = step_cnt_ff + 1'b1;
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      sum_in       = sum_ff;
      clamp_in     = clamp_ff;
      have_prev_in = have_prev_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_item) begin
         have_prev_in = 1'b1;
      end
      if (cmd.accumulate) begin
         if (sum_ext[SUM_WIDTH]) begin
            sum_in   = SUM_MAX;
            clamp_in = 1'b1;
         end else begin
            sum_in = sum_ext[SUM_WIDTH-1:0];
         end
      end
      if (cmd.emit) begin
         sum_in       = '0;
         clamp_in     = 1'b0;
         have_prev_in = 1'b0;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         sum_ff       <= '0;
         clamp_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         sum_ff       <= sum_in;
         clamp_ff     <= clamp_in;
         out_valid_ff <= out_valid_in;
         if (cmd.load_item) begin
            prev_x_ff <= point_x;
            prev_y_ff <= point_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         abs_x_ff   <= abs_x_in;
         abs_y_ff   <= abs_y_in;
         segment_ff <= !part_start && have_prev_ff;
         last_ff    <= last_point;
      end
      if (cmd.square) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_cnt_ff <= step_cnt_in;
      if (cmd.emit) begin
         out_total_ff <= sum_ff;
         out_sat_ff   <= clamp_ff;
      end
   end

   always_comb begin
      status           = '0;
      status.segment   = segment_ff;
      status.last      = last_ff;
      status.root_done = (step_cnt_ff == LAST_STEP);
      status.out_free  = out_free;
   end

   assign rsp_valid        = out_valid_ff;
   assign total_length     = out_total_ff;
   assign length_saturated = out_sat_ff;

   `MPL_ASSERT_IMPL(a_clamp_at_max, clock, reset, clamp_ff, sum_ff == SUM_MAX)
   `MPL_ASSERT_NEXT(a_sum_grows, clock, reset, cmd.accumulate, sum_ff >= $past(sum_ff))
   `MPL_ASSERT_NEXT(a_emit_clears, clock, reset, cmd.emit,
                    out_valid_ff && sum_ff == '0 && !clamp_ff && !have_prev_ff)

endmodule

// ===== src/multipart_path_length.sv =====
// Top level of the multi-part polyline length accumulator
//
// Usage: vertices enter on req_port (valid/ready), each with signed Q16.4 point_x and
// point_y, part_start marking the first vertex of a part and last_point marking the
// final vertex of the shape. Within a part, each vertex after the first adds the
// truncated Euclidean distance to the previous vertex to a 48-bit running sum.
// On last_point one transaction leaves on rsp_port: total_length (unsigned Q44.4) and
// length_saturated, set when the sum clamped at its maximum.
// Sequencing: a new vertex is accepted only once the previous one is finished.
// A vertex that closes a segment passes through the deltas, the squares, their sum,
// the bit-pair square root and the add; a vertex that opens a part passes through
// the deltas and the squares only; a last vertex adds an emit step. The square root
// iteration is the longest step. Result: rsp_valid rises after the emit step that
// follows a last vertex, which waits until the output register is free.
// Results sit in an output register; a stalled receiver blocks the block only when a
// second result is ready while the first is still held.
// Reset: synchronous, active high; clears the previous vertex, the sum and the flag.
module multipart_path_length
   import mpl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   mpl_req_if.sink      req_port,
   mpl_rsp_if.source    rsp_port
);

   cmd_type    cmd;
   status_type status;

   mpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .point_x          (req_port.point_x),
      .point_y          (req_port.point_y),
      .part_start       (req_port.part_start),
      .last_point       (req_port.last_point),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_port.ready),
      .rsp_valid        (rsp_port.valid),
      .total_length     (rsp_port.total_length),
      .length_saturated (rsp_port.length_saturated)
   );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for multipart_path_length: directed and random polylines checked against a predicted length
`timescale 1ns / 100ps

module tb_top
   import mpl_pkg::*;
();

   localparam int                CLOCK_PERIOD = 12;
   localparam int                VERTEX_COUNT = 650;
   localparam int                TAIL_ITEMS   = 60;
   localparam int                CYCLE_LIMIT  = 200000;
   localparam longint unsigned   SUM_MAX      = (64'd1 << SUM_WIDTH) - 1;
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic                          part_start;
      logic                          last_point;
   } vertex_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0] total;
      logic                 saturated;
   } path_total_type;

   logic clock;
   logic reset;

   mpl_req_if req_if ();
   mpl_rsp_if rsp_if ();

   multipart_path_length DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   vertex_type     vertex_queue[$];
   path_total_type predicted_totals[$];

   logic signed [COORD_WIDTH-1:0] last_x;
   logic signed [COORD_WIDTH-1:0] last_y;
   logic                          have_last;
   logic [SUM_WIDTH-1:0]          running_length;
   logic                          running_clamped;

   logic req_fire;
   logic tail_phase;
   int   req_gap;
   int   rsp_gap;
   int   error_count;
   int   cycle_count;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 21; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned segment_length(logic signed [COORD_WIDTH-1:0] x,
                                                      logic signed [COORD_WIDTH-1:0] y,
                                                      logic signed [COORD_WIDTH-1:0] px,
                                                      logic signed [COORD_WIDTH-1:0] py);
      longint          dx;
      longint          dy;
      longint unsigned sq;
      dx = longint'(x) - longint'(px);
      dy = longint'(y) - longint'(py);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = longint'(dx * dx) + longint'(dy * dy);
      return floor_root(sq);
   endfunction

   task automatic track_vertex(vertex_type v);
      longint unsigned seg;
      longint unsigned room;
      path_total_type  done;
      if (!v.part_start && have_last) begin
         seg  = segment_length(v.x, v.y, last_x, last_y);
         room = SUM_MAX - longint'(running_length);
         if (seg > room) begin
            running_length  = SUM_MAX[SUM_WIDTH-1:0];
            running_clamped = 1'b1;
         end else begin
            running_length = running_length + seg[SUM_WIDTH-1:0];
         end
      end
      last_x    = v.x;
      last_y    = v.y;
      have_last = 1'b1;
      if (v.last_point) begin
         done.total     = running_length;
         done.saturated = running_clamped;
         predicted_totals.insert(predicted_totals.size(), done);
         running_length  = '0;
         running_clamped = 1'b0;
         have_last       = 1'b0;
      end
   endtask

   task automatic push_vertex(int x, int y, logic part_start, logic last_point);
      vertex_type v;
      v.x          = COORD_WIDTH'(x);
      v.y          = COORD_WIDTH'(y);
      v.part_start = part_start;
      v.last_point = last_point;
      vertex_queue.insert(vertex_queue.size(), v);
   endtask

   function automatic logic signed [COORD_WIDTH-1:0] next_coord(
         logic signed [COORD_WIDTH-1:0] base);
      int unsigned mode;
      int          span;
      mode = $urandom_range(0, 9);
      if (mode < 4 || mode == 9) return COORD_WIDTH'($urandom);
      if (mode < 8) begin
         span = 1 << $urandom_range(0, 12);
         return COORD_WIDTH'(base + $urandom_range(0, 2 * span) - span);
      end
      case ($urandom_range(0, 3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // sample handshakes and track accepted vertices
   always @(posedge clock) begin
      req_fire   <= req_if.valid && req_if.ready;
      tail_phase <= vertex_queue.size() < TAIL_ITEMS;
      if (reset) begin
         have_last       = 1'b0;
         last_x          = '0;
         last_y          = '0;
         running_length  = '0;
         running_clamped = 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         track_vertex('{x: req_if.point_x, y: req_if.point_y,
                        part_start: req_if.part_start, last_point: req_if.last_point});
      end
   end

   // check each result transaction against the oldest predicted total
   always @(posedge clock) begin
      path_total_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (predicted_totals.size() == 0) begin
            $display("%0t: unexpected result total_length=%0d saturated=%0b",
                     $time, rsp_if.total_length, rsp_if.length_saturated);
            error_count++;
         end else begin
            want = predicted_totals.pop_front();
            if (rsp_if.total_length !== want.total) begin
               $display("%0t: total_length expected %0d actual %0d",
                        $time, want.total, rsp_if.total_length);
               error_count++;
            end
            if (rsp_if.length_saturated !== want.saturated) begin
               $display("%0t: length_saturated expected %0b actual %0b",
                        $time, want.saturated, rsp_if.length_saturated);
               error_count++;
            end
         end
      end
   end

   // vertex driver
   always @(negedge clock) begin
      vertex_type v;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.point_x    <= '0;
         req_if.point_y    <= '0;
         req_if.part_start <= 1'b0;
         req_if.last_point <= 1'b0;
         req_gap = 0;
      end else if (req_if.valid && !req_fire) begin
         // hold the pending transaction
      end else if (req_gap > 0) begin
         req_if.valid <= 1'b0;
         req_gap--;
      end else if (vertex_queue.size() > 0 && !tail_phase && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         req_gap = $urandom_range(0, 5);
      end else if (vertex_queue.size() > 0) begin
         v = vertex_queue.pop_front();
         req_if.point_x    <= v.x;
         req_if.point_y    <= v.y;
         req_if.part_start <= v.part_start;
         req_if.last_point <= v.last_point;
         req_if.valid      <= 1'b1;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // result receiver stalls
   always @(negedge clock) begin
      if (reset || tail_phase) begin
         rsp_if.ready <= 1'b1;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap--;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                            made;
      int                            n;
      bit                            noisy;
      logic                          start;
      logic signed [COORD_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] cy;

      reset = 1'b1;

      // continuation with no previous vertex opens a part
      push_vertex(0, 0, 1'b0, 1'b0);
      push_vertex(48, 64, 1'b0, 1'b1);
      // single-vertex shape
      push_vertex(int'(COORD_MAX), int'(COORD_MIN), 1'b1, 1'b1);
      // extreme coordinates, with a part break between them
      push_vertex(int'(COORD_MIN), int'(COORD_MIN), 1'b1, 1'b0);
      push_vertex(int'(COORD_MAX), int'(COORD_MAX), 1'b0, 1'b0);
      push_vertex(int'(COORD_MAX), int'(COORD_MIN), 1'b0, 1'b0);
      push_vertex(int'(COORD_MIN), int'(COORD_MAX), 1'b1, 1'b0);
      push_vertex(int'(COORD_MIN), int'(COORD_MIN), 1'b0, 1'b1);
      // single-vertex part inside a shape, zero-length segment at the end
      push_vertex(10, 10, 1'b1, 1'b0);
      push_vertex(20, 10, 1'b0, 1'b0);
      push_vertex(0, 0, 1'b1, 1'b0);
      push_vertex(5, 5, 1'b1, 1'b0);
      push_vertex(5, 5, 1'b0, 1'b1);
      // last vertex opens a new part
      push_vertex(0, 0, 1'b1, 1'b0);
      push_vertex(16, 0, 1'b0, 1'b0);
      push_vertex(100, 100, 1'b1, 1'b1);
      // truncated root
      push_vertex(0, 0, 1'b1, 1'b0);
      push_vertex(1, 1, 1'b0, 1'b1);

      made = vertex_queue.size();
      cx   = '0;
      cy   = '0;
      while (made < VERTEX_COUNT) begin
         noisy = $urandom_range(0, 6) == 0;
         n     = $urandom_range(1, 10);
         for (int k = 0; k < n; k++) begin
            cx = next_coord(cx);
            cy = next_coord(cy);
            if (noisy) start = 1'($urandom_range(0, 1));
            else if (k == 0) start = $urandom_range(0, 7) != 0;
            else start = $urandom_range(0, 5) == 0;
            push_vertex(int'(cx), int'(cy), start, k == n - 1);
            made++;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (vertex_queue.size() > 0 || req_if.valid) @(posedge clock);
      while (predicted_totals.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/mpl_pkg.sv
src/mpl_req_if.sv
src/mpl_rsp_if.sv
src/mpl_ctrl.sv
src/mpl_datapath.sv
src/multipart_path_length.sv
verif/tb_top.sv
